// File: hw/rtl/r2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package r2h_pkg;

  // Default width of one colour component
  localparam int unsigned COMPONENT_BITS_DEF = 8;

  // Hue is a Q0.16 fraction of the circle
  localparam int unsigned HUE_BITS = 16;

endpackage

// File: hw/rtl/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Streaming RGB to HSV conversion, fixed point, one pixel per clock unless the pipeline is full.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle while some stage is empty or the output is ready,
// and returns one HSV beat per pixel through HUE_BITS + 2 stages. The count
// is set by the hue divider, which resolves one quotient bit per stage; the
// saturation divider runs alongside it in the first COMPONENT_BITS. Every stage holds
// its own valid bit and fills bubbles under backpressure, so the block keeps
// taking pixels while a finished beat waits at the output.
module rgb_to_hsv_pixel #(
  parameter int unsigned COMPONENT_BITS = r2h_pkg::COMPONENT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // red, green, blue from the lowest bit up, zero padded to bytes
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hue, saturation, brightness from the lowest bit up, zero padded to bytes
  output logic [((r2h_pkg::HUE_BITS+2*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata
);
  import r2h_pkg::*;

  localparam int unsigned CB   = COMPONENT_BITS;
  localparam int unsigned HB   = HUE_BITS;
  localparam int unsigned NS   = HUE_BITS;       // divider stages
  localparam int unsigned L    = NS + 2;         // all stages
  localparam int unsigned SW   = CB + 3;         // width of 6*delta
  localparam int unsigned NW   = CB + 4;         // signed numerator width
  localparam int unsigned OW   = ((HB+2*CB+7)/8)*8;

  // Per-stage valid bits and advance enables
  logic [L-1:0] v_q;
  logic [L-1:0] go;

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    go[L-1] = !v_q[L-1] || m_axis_tready;
    for (int i = L-2; i >= 0; i--) begin
      go[i] = !v_q[i] || go[i+1];
    end
  end

  assign s_axis_tready = go[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < L; i++) begin
        if (go[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage A: unpack, find largest and smallest component
  logic [CB-1:0] in_r, in_g, in_b, in_hi, in_lo;
  logic [CB-1:0] a_r_q, a_g_q, a_b_q, a_hi_q, a_lo_q;

  assign in_r = s_axis_tdata[CB-1:0];
  assign in_g = s_axis_tdata[2*CB-1:CB];
  assign in_b = s_axis_tdata[3*CB-1:2*CB];

  always_comb begin
    in_hi = (in_r > in_g) ? in_r : in_g;
    in_hi = (in_hi > in_b) ? in_hi : in_b;
    in_lo = (in_r < in_g) ? in_r : in_g;
    in_lo = (in_lo < in_b) ? in_lo : in_b;
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      a_r_q  <= in_r;
      a_g_q  <= in_g;
      a_b_q  <= in_b;
      a_hi_q <= in_hi;
      a_lo_q <= in_lo;
    end
  end

  // Divider pipeline registers, index 0 is stage B
  logic [SW-1:0]   hrem_q [NS+1];
  logic [SW-1:0]   span_q [NS+1];
  logic [HB-1:0]   hq_q   [NS+1];
  logic [CB-1:0]   srem_q [NS+1];
  logic [CB-1:0]   slo_q  [NS+1];
  logic [CB-1:0]   sq_q   [NS+1];
  logic [CB-1:0]   hi_q   [NS+1];
  logic            grey_q [NS+1];

  // Stage B: delta, hue numerator and divisor, saturation dividend
  logic [CB-1:0]        b_delta;
  logic [2*CB-1:0]      b_sdiv;
  logic signed [NW-1:0] b_d, b_num;
  logic [SW-1:0]        b_span;

  always_comb begin
    b_delta = a_hi_q - a_lo_q;
    b_sdiv  = {b_delta, CB'(0)} - {CB'(0), b_delta};
    b_d     = signed'({4'b0, b_delta});
    b_span  = {1'b0, b_delta, 2'b0} + {2'b0, b_delta, 1'b0};
    if (a_r_q == a_hi_q) begin
      b_num = signed'({4'b0, a_g_q}) - signed'({4'b0, a_b_q});
    end else if (a_g_q == a_hi_q) begin
      b_num = (b_d <<< 1) + signed'({4'b0, a_b_q}) - signed'({4'b0, a_r_q});
    end else begin
      b_num = (b_d <<< 2) + signed'({4'b0, a_r_q}) - signed'({4'b0, a_g_q});
    end
    if (b_num < 0) begin
      b_num = b_num + signed'({1'b0, b_span});
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      hrem_q[0] <= b_num[SW-1:0];
      span_q[0] <= b_span;
      hq_q[0]   <= '0;
      srem_q[0] <= b_sdiv[2*CB-1:CB];
      slo_q[0]  <= b_sdiv[CB-1:0];
      sq_q[0]   <= '0;
      hi_q[0]   <= a_hi_q;
      grey_q[0] <= (b_delta == '0);
    end
  end

  // Restoring division, one hue quotient bit per stage, one saturation bit in the first CB
  for (genvar k = 1; k <= NS; k++) begin : g_div
    logic [SW:0]   ht;
    logic          hbit;
    logic [CB:0]   st;
    logic          sbit;

    always_comb begin
      ht   = {hrem_q[k-1], 1'b0};
      hbit = (ht >= {1'b0, span_q[k-1]});
      st   = {srem_q[k-1], slo_q[k-1][CB-1]};
      sbit = (st >= {1'b0, hi_q[k-1]});
    end

    always_ff @(posedge clk_i) begin
      if (go[k+1]) begin
        hrem_q[k] <= hbit ? SW'(ht - {1'b0, span_q[k-1]}) : ht[SW-1:0];
        hq_q[k]   <= {hq_q[k-1][HB-2:0], hbit};
        span_q[k] <= span_q[k-1];
        hi_q[k]   <= hi_q[k-1];
        grey_q[k] <= grey_q[k-1];
        if (k <= CB) begin
          srem_q[k] <= sbit ? CB'(st - {1'b0, hi_q[k-1]}) : st[CB-1:0];
          slo_q[k]  <= slo_q[k-1] << 1;
          sq_q[k]   <= {sq_q[k-1][CB-2:0], sbit};
        end else begin
          srem_q[k] <= srem_q[k-1];
          slo_q[k]  <= slo_q[k-1];
          sq_q[k]   <= sq_q[k-1];
        end
      end
    end
  end

  // Drive the result beat; grey pixels carry zero hue and saturation
  logic [HB-1:0] out_hue;
  logic [CB-1:0] out_sat;

  assign out_hue = grey_q[NS] ? '0 : hq_q[NS];
  assign out_sat = grey_q[NS] ? '0 : sq_q[NS];

  assign m_axis_tvalid = v_q[L-1];
  assign m_axis_tdata  = OW'({hi_q[NS], out_sat, out_hue});

  // Checks
  ap_grey_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[HB+CB-1:HB] == '0) |-> (m_axis_tdata[HB-1:0] == '0))
    else $error("nonzero hue on a grey pixel");

  ap_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[HB+2*CB-1:HB+CB] == '0)
      |-> (m_axis_tdata[HB+CB-1:0] == '0))
    else $error("black pixel with nonzero hue or saturation");

  ap_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

// File: tb/sv/rgb_to_hsv_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_checker
// Watches both stream channels of the converter, predicts the HSV beat for
// every accepted pixel and compares it field by field with the output beats.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

  hsv_t hsv_q[$];

  // Integer HSV conversion of one pixel
  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int   hi, lo, delta, num;
    hsv_t res;
    hi = r; if (g > hi) hi = g; if (b > hi) hi = b;
    lo = r; if (g < lo) lo = g; if (b < lo) lo = b;
    delta = hi - lo;
    res.val = hi[7:0];
    res.sat = '0;
    res.hue = '0;
    if (delta != 0) begin
      res.sat = 8'((delta * 255) / hi);
      if (r >= hi) num = int'(g) - int'(b);
      else if (g >= hi) num = 2 * delta + int'(b) - int'(r);
      else num = 4 * delta + int'(r) - int'(g);
      if (num < 0) num += 6 * delta;
      res.hue = 16'((num * 65536) / (6 * delta));
    end
    return res;
  endfunction

  assign pending_o = hsv_q.size();

  // Queue the expected beat on input, compare on output
  always @(posedge clk_i) begin
    hsv_t exp_b, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        hsv_q.push_back(convert_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                      s_axis_tdata[23:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tdata[31:24]};
        if (hsv_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          exp_b = hsv_q.pop_front();
          if (got.hue !== exp_b.hue) begin
            $error("hue: expected %0d, actual %0d", exp_b.hue, got.hue);
            fail_count_o++;
          end
          if (got.sat !== exp_b.sat) begin
            $error("saturation: expected %0d, actual %0d", exp_b.sat, got.sat);
            fail_count_o++;
          end
          if (got.val !== exp_b.val) begin
            $error("brightness: expected %0d, actual %0d", exp_b.val, got.val);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/rgb_to_hsv_pixel_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_test
// Drives directed and random pixels through the converter with bursty input
// and stalling output, including one long output hold-off, and reports.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_test;

  localparam int N_RANDOM = 730;
  localparam int WATCHDOG = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red, green, blue
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // hue, saturation, brightness
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          stim_done;
  bit          long_hold;

  rgb_to_hsv_pixel u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rgb_to_hsv_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Send one pixel; hold valid until the beat is taken
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    s_axis_tdata  <= {b, g, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Random gap between bursts, sometimes none
  task automatic burst_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Receiver: phases of free flow and random stalls, plus one long hold-off
  initial begin
    int phase;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(negedge clk_i);
        long_hold = 1'b0;
      end
      phase = $urandom_range(0, 2);
      repeat ($urandom_range(5, 40)) begin
        if (phase == 0) m_axis_tready <= 1'b1;
        else if (phase == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 3) == 0);
        @(negedge clk_i);
      end
    end
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [7:0] r, g, b;
    int         burst;
    int         kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    stim_done     = 1'b0;
    long_hold     = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: black, white, grey, primaries, ties and hue wrap
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd255);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd200, 8'd200, 8'd199);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd0,   8'd1,   8'd1);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);

    // Long output hold-off while pixels keep coming
    long_hold = 1'b1;

    // Random bursts: mostly full range, some near-grey pixels
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
        kind = $urandom_range(0, 7);
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        if (kind == 0) begin
          g = r ^ 8'($urandom_range(0, 1));
          b = r ^ 8'($urandom_range(0, 3));
        end else if (kind == 1) begin
          g = r;
        end
        send_pixel(r, g, b);
      end
      burst_gap();
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;

    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
